>>> sv/stids_pkg.sv
// package for the shift table block: sizes, request and result structs,
// cell control types and request codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stids_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 6;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_APPEND    = 3'd1;
  localparam logic [2:0] REQ_INS_POS   = 3'd2;
  localparam logic [2:0] REQ_DELETE    = 3'd3;
  localparam logic [2:0] REQ_SEARCH    = 3'd4;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [6:0] count;
    logic       status;
  } rsp_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_LOAD,
    CM_LOWER,
    CM_UPPER
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       mark;
    logic       live;
  } cell_ctl_t;

  typedef struct packed {
    logic                  ins;
    logic                  mark;
    logic                  compact;
    logic [CMP_W-1:0]      ins_pos;
    logic [VALUE_BITS-1:0] key;
    logic [CNT_W-1:0]      count;
  } table_cmd_t;

  // low VALUE_BITS bits of the request word, zero-extended when wider
  function automatic logic [VALUE_BITS-1:0] to_word(input logic [31:0] x);
    logic [63:0] w;
    w = {32'b0, x};
    return w[VALUE_BITS-1:0];
  endfunction

  // count as carried in the result field
  function automatic logic [6:0] to_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+6:0] w;
    w = {7'b0, c};
    return w[6:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/stids_cell.sv
// one table cell: holds an entry and its delete mark, loads from the request
// word or from either neighbor; depends on stids_pkg
`timescale 1ns / 1ps
`default_nettype none

module stids_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire stids_pkg::cell_ctl_t            ctl,
  input  wire logic [stids_pkg::VALUE_BITS-1:0] key,
  input  wire logic [stids_pkg::VALUE_BITS-1:0] lower_data,
  input  wire logic [stids_pkg::VALUE_BITS-1:0] upper_data,
  input  wire logic                            upper_kill,
  output logic [stids_pkg::VALUE_BITS-1:0]     data,
  output logic                                 kill,
  output logic                                 match
);
  import stids_pkg::*;

  assign match = (data == key);

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_LOAD:  data <= key;
      CM_LOWER: data <= lower_data;
      CM_UPPER: data <= upper_data;
      default:  data <= data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kill <= 1'b0;
    end else if (ctl.mark) begin
      kill <= match & ctl.live;
    end else if (ctl.mode == CM_UPPER) begin
      kill <= upper_kill;
    end
  end

endmodule

`default_nettype wire

>>> sv/stids_ctrl.sv
// request sequencer: takes a request, drives the cell row, steps the
// compaction, keeps the fill count and holds the result; depends on stids_pkg
`timescale 1ns / 1ps
`default_nettype none

module stids_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire stids_pkg::req_t     req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output stids_pkg::rsp_t          rsp,
  input  wire logic                any_match,
  input  wire logic                any_kill,
  output stids_pkg::table_cmd_t    cmd
);
  import stids_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT,
    ST_RESULT
  } state_t;

  state_t           state;
  req_t             cur;
  logic [CNT_W-1:0] cnt;
  rsp_t             pend;

  logic             is_ins;
  logic             is_look;
  logic             full;
  logic             can_send;
  logic             rsp_load;
  logic [CNT_W-1:0] cnt_exec;
  rsp_t             exec_rsp;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign req_ready = (state == ST_IDLE);
  assign can_send  = !rsp_valid || rsp_ready;

  assign is_ins  = (cur.req_type == REQ_INS_FRONT) || (cur.req_type == REQ_APPEND) ||
                   (cur.req_type == REQ_INS_POS);
  assign is_look = (cur.req_type == REQ_DELETE) || (cur.req_type == REQ_SEARCH);
  assign full    = (cnt == CNT_W'(DEPTH));
  assign pos_ext = CMP_W'(cur.position);
  assign cnt_ext = CMP_W'(cnt);

  always_comb begin
    cmd.ins     = (state == ST_EXEC) && is_ins && !full;
    cmd.mark    = (state == ST_EXEC) && (cur.req_type == REQ_DELETE);
    cmd.compact = (state == ST_COMPACT) && any_kill;
    cmd.key     = to_word(cur.value);
    cmd.count   = cnt;
    if (cur.req_type == REQ_INS_FRONT) begin
      cmd.ins_pos = '0;
    end else if (cur.req_type == REQ_APPEND || pos_ext >= cnt_ext) begin
      cmd.ins_pos = cnt_ext;
    end else begin
      cmd.ins_pos = pos_ext;
    end
  end

  always_comb begin
    cnt_exec        = cmd.ins ? cnt + CNT_W'(1) : cnt;
    exec_rsp.found  = is_look && any_match;
    exec_rsp.count  = to_count(cnt_exec);
    exec_rsp.status = (is_ins && full) ? STATUS_DROPPED : STATUS_DONE;
  end

  // result register loads this cycle
  always_comb begin
    case (state)
      ST_EXEC:    rsp_load = can_send && !(cur.req_type == REQ_DELETE && any_match);
      ST_COMPACT: rsp_load = can_send && !any_kill;
      ST_RESULT:  rsp_load = can_send;
      default:    rsp_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cnt  <= cnt_exec;
          pend <= exec_rsp;
          if (cur.req_type == REQ_DELETE && any_match) begin
            state <= ST_COMPACT;
          end else if (can_send) begin
            rsp       <= exec_rsp;
            state     <= ST_IDLE;
          end else begin
            state <= ST_RESULT;
          end
        end
        ST_COMPACT: begin
          if (any_kill) begin
            cnt <= cnt - CNT_W'(1);
          end else if (can_send) begin
            rsp        <= '{found: pend.found, count: to_count(cnt), status: pend.status};
            state      <= ST_IDLE;
          end else begin
            pend.count <= to_count(cnt);
            state      <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (can_send) begin
            rsp       <= pend;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_EXEC))
    else $error("transfer did not start execution");

  a_compact_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPACT && any_kill) |=> (cnt == $past(cnt) - CNT_W'(1)))
    else $error("compaction step did not drop count");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && is_ins && full) |=> (cnt == $past(cnt)))
    else $error("insert into full table changed count");

endmodule

`default_nettype wire

>>> sv/shift_table_insert_delete_search.sv
// top level of the shift table: sequencer plus a row of DEPTH cells with
// neighbor links; depends on stids_pkg, stids_cell, stids_ctrl
//
//   channel  signals                    payload
//   request  req_valid / req_ready      req  (req_type, value, position)
//   result   rsp_valid / rsp_ready      rsp  (found, count, status)
//
// inserts, searches and deletes that find nothing go through transfer, then
// one shift or compare step
// a delete that removes k > 0 entries runs mark, one cell shift per removed
// entry through the row, then a final check
// one request in flight; a finished result waits in the output register
// synchronous reset clears the fill count and marks, entries are not cleared
`timescale 1ns / 1ps
`default_nettype none

module shift_table_insert_delete_search (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire stids_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output stids_pkg::rsp_t      rsp
);
  import stids_pkg::*;

  table_cmd_t                  cmd;
  cell_ctl_t                   ctl   [DEPTH];
  logic [VALUE_BITS-1:0]       data  [DEPTH];
  logic [DEPTH-1:0]            kill;
  logic [DEPTH-1:0]            match;
  logic [DEPTH-1:0]            live;
  logic [DEPTH-1:0]            shift_up;
  logic                        any_match;
  logic                        any_kill;

  assign any_match = |(match & live);
  assign any_kill  = |kill;

  stids_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .any_match (any_match),
    .any_kill  (any_kill),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lower_data;
    logic [VALUE_BITS-1:0] upper_data;
    logic                  upper_kill;

    assign live[i] = (CNT_W'(i) < cmd.count);

    // at or above the lowest marked entry
    if (i == 0) begin : g_first
      assign shift_up[i] = kill[i];
      assign lower_data  = '0;
    end else begin : g_rest
      assign shift_up[i] = shift_up[i-1] | kill[i];
      assign lower_data  = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_data = data[i];
      assign upper_kill = 1'b0;
    end else begin : g_mid
      assign upper_data = data[i+1];
      assign upper_kill = kill[i+1];
    end

    always_comb begin
      ctl[i].mark = cmd.mark;
      ctl[i].live = live[i];
      if (cmd.ins && CMP_W'(i) > cmd.ins_pos) begin
        ctl[i].mode = CM_LOWER;
      end else if (cmd.ins && CMP_W'(i) == cmd.ins_pos) begin
        ctl[i].mode = CM_LOAD;
      end else if (cmd.compact && shift_up[i]) begin
        ctl[i].mode = CM_UPPER;
      end else begin
        ctl[i].mode = CM_HOLD;
      end
    end

    stids_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[i]),
      .key        (cmd.key),
      .lower_data (lower_data),
      .upper_data (upper_data),
      .upper_kill (upper_kill),
      .data       (data[i]),
      .kill       (kill[i]),
      .match      (match[i])
    );
  end

endmodule

`default_nettype wire
